### design/adpcm_se_pkg.sv
// shared types, constants and the step size table for the adpcm search encoder
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package adpcm_se_pkg;

    localparam logic [6:0]  IDX_MAX   = 7'd88;
    localparam logic [15:0] PRED_POS  = 16'sh7fff;
    localparam logic [15:0] PRED_NEG  = 16'sh8000;

    typedef enum logic [1:0] {
        CFG_LOOKAHEAD   = 2'd0,
        CFG_START_PRED  = 2'd1,
        CFG_START_INDEX = 2'd2
    } t_cfg_idx;

    function automatic logic [14:0] step_size(input logic [6:0] idx);
        logic [14:0] s;
        unique case (idx)
            7'd0:  s = 15'd7;     7'd1:  s = 15'd8;     7'd2:  s = 15'd9;
            7'd3:  s = 15'd10;    7'd4:  s = 15'd11;    7'd5:  s = 15'd12;
            7'd6:  s = 15'd13;    7'd7:  s = 15'd14;    7'd8:  s = 15'd16;
            7'd9:  s = 15'd17;    7'd10: s = 15'd19;    7'd11: s = 15'd21;
            7'd12: s = 15'd23;    7'd13: s = 15'd25;    7'd14: s = 15'd28;
            7'd15: s = 15'd31;    7'd16: s = 15'd34;    7'd17: s = 15'd37;
            7'd18: s = 15'd41;    7'd19: s = 15'd45;    7'd20: s = 15'd50;
            7'd21: s = 15'd55;    7'd22: s = 15'd60;    7'd23: s = 15'd66;
            7'd24: s = 15'd73;    7'd25: s = 15'd80;    7'd26: s = 15'd88;
            7'd27: s = 15'd97;    7'd28: s = 15'd107;   7'd29: s = 15'd118;
            7'd30: s = 15'd130;   7'd31: s = 15'd143;   7'd32: s = 15'd157;
            7'd33: s = 15'd173;   7'd34: s = 15'd190;   7'd35: s = 15'd209;
            7'd36: s = 15'd230;   7'd37: s = 15'd253;   7'd38: s = 15'd279;
            7'd39: s = 15'd307;   7'd40: s = 15'd337;   7'd41: s = 15'd371;
            7'd42: s = 15'd408;   7'd43: s = 15'd449;   7'd44: s = 15'd494;
            7'd45: s = 15'd544;   7'd46: s = 15'd598;   7'd47: s = 15'd658;
            7'd48: s = 15'd724;   7'd49: s = 15'd796;   7'd50: s = 15'd876;
            7'd51: s = 15'd963;   7'd52: s = 15'd1060;  7'd53: s = 15'd1166;
            7'd54: s = 15'd1282;  7'd55: s = 15'd1411;  7'd56: s = 15'd1552;
            7'd57: s = 15'd1707;  7'd58: s = 15'd1878;  7'd59: s = 15'd2066;
            7'd60: s = 15'd2272;  7'd61: s = 15'd2499;  7'd62: s = 15'd2749;
            7'd63: s = 15'd3024;  7'd64: s = 15'd3327;  7'd65: s = 15'd3660;
            7'd66: s = 15'd4026;  7'd67: s = 15'd4428;  7'd68: s = 15'd4871;
            7'd69: s = 15'd5358;  7'd70: s = 15'd5894;  7'd71: s = 15'd6484;
            7'd72: s = 15'd7132;  7'd73: s = 15'd7845;  7'd74: s = 15'd8630;
            7'd75: s = 15'd9493;  7'd76: s = 15'd10442; 7'd77: s = 15'd11487;
            7'd78: s = 15'd12635; 7'd79: s = 15'd13899; 7'd80: s = 15'd15289;
            7'd81: s = 15'd16818; 7'd82: s = 15'd18500; 7'd83: s = 15'd20350;
            7'd84: s = 15'd22385; 7'd85: s = 15'd24623; 7'd86: s = 15'd27086;
            7'd87: s = 15'd29794;
            default: s = 15'd32767;
        endcase
        return s;
    endfunction

    function automatic logic signed [4:0] idx_adjust(input logic [2:0] mag);
        logic signed [4:0] a;
        unique case (mag)
            3'd4:    a = 5'sd2;
            3'd5:    a = 5'sd4;
            3'd6:    a = 5'sd6;
            3'd7:    a = 5'sd8;
            default: a = -5'sd1;
        endcase
        return a;
    endfunction

endpackage

`default_nettype wire

### design/adpcm_se.sv
// top level of the adpcm search encoder: stream ports, config registers,
// search sequencer and coder state; uses adpcm_se_pkg and adpcm_se_unit
`timescale 1ns / 1ps
`default_nettype none

// Usage:
//   input stream: one transfer per PCM sample; tdata carries the sample and
//   the following sample, tuser carries has_next and start_req.
//   output stream: one transfer per sample with the chosen nibble, the 8-bit
//   reconstruction and the packed byte; tuser carries byte_ready.
//   config port: write enable, register index and data, written while idle.
// Sequencing: every nibble trial runs through one three-stage trial unit. Each
//   of the 16 candidates is tried in turn, and a candidate that enters the
//   lookahead search then issues 16 trials on the following sample. A final
//   trial of the chosen nibble gives the state update. An item runs 0 to 16
//   lookahead searches.
// s_axis_tready is high only while no item is in work; a finished result sits
//   in the output register and the next item is accepted meanwhile. If the
//   receiver stalls, the following item waits at its final step until the
//   output register frees up.
// Reset clears config, predictor, step index, held nibble and byte parity.
module adpcm_search_encoder
    import adpcm_se_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [31:0] s_axis_tdata,  // sample[15:0], next_sample[31:16]
    input  wire logic [1:0]  s_axis_tuser,  // has_next[0], start_req[1]
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [23:0]      m_axis_tdata,  // code_nibble[3:0], recon_sample[11:4],
                                            // packed_byte[19:12], zero[23:20]
    output logic [0:0]       m_axis_tuser,  // byte_ready[0]
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_addr,
    input  wire logic [15:0] i_cfg_wdata
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_OISSUE,
        S_OWAIT,
        S_INNER,
        S_OCMP,
        S_FISSUE,
        S_FWAIT
    } t_state;

    t_state             r_state;
    logic               r_look_cfg;
    logic signed [15:0] r_start_pred;
    logic [6:0]         r_start_idx;

    logic signed [15:0] r_pred;
    logic [6:0]         r_idx;
    logic [3:0]         r_held;
    logic               r_odd;

    logic signed [15:0] r_cur, r_nxt;
    logic               r_has_next;
    logic               r_look;

    logic [3:0]         r_k;
    logic [3:0]         r_best;
    logic               r_have;
    logic [32:0]        r_best_d;
    logic [32:0]        r_d;
    logic signed [15:0] r_tp;
    logic [6:0]         r_ti;
    logic [4:0]         r_iss;
    logic [3:0]         r_got;
    logic [31:0]        r_min;

    logic               r_out_vld;
    logic [3:0]         r_o_nib;
    logic [7:0]         r_o_recon;
    logic [7:0]         r_o_byte;
    logic               r_o_ready;

    logic               u_go;
    logic signed [15:0] u_pred;
    logic [6:0]         u_idx;
    logic [3:0]         u_nib;
    logic signed [15:0] u_tgt;
    logic               u_done;
    logic signed [15:0] u_tp;
    logic [6:0]         u_ti;
    logic [31:0]        u_sq;

    logic               in_xfer;
    logic               out_free;
    logic               commit;
    logic [31:0]        min_next;
    logic               beats;

    assign in_xfer  = s_axis_tvalid && s_axis_tready;
    assign out_free = !r_out_vld || m_axis_tready;
    assign commit   = (r_state == S_FWAIT) && u_done && out_free;
    assign min_next = (r_got == 4'd0 || u_sq < r_min) ? u_sq : r_min;
    assign beats    = !r_have || (r_d < r_best_d);

    always_comb begin
        u_go   = 1'b0;
        u_pred = r_pred;
        u_idx  = r_idx;
        u_nib  = r_k;
        u_tgt  = r_cur;
        unique case (r_state)
            S_OISSUE: u_go = 1'b1;
            S_INNER: begin
                u_go   = !r_iss[4];
                u_pred = r_tp;
                u_idx  = r_ti;
                u_nib  = r_iss[3:0];
                u_tgt  = r_nxt;
            end
            S_FISSUE: begin
                u_go  = 1'b1;
                u_nib = r_best;
            end
            default: u_go = 1'b0;
        endcase
    end

    adpcm_se_unit u_unit (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_go     (u_go),
        .i_pred   (u_pred),
        .i_idx    (u_idx),
        .i_nib    (u_nib),
        .i_target (u_tgt),
        .o_done   (u_done),
        .o_pred   (u_tp),
        .o_idx    (u_ti),
        .o_sq     (u_sq)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_look_cfg   <= 1'b0;
            r_start_pred <= '0;
            r_start_idx  <= '0;
            r_pred       <= '0;
            r_idx        <= '0;
            r_held       <= '0;
            r_odd        <= 1'b0;
            r_out_vld    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (t_cfg_idx'(i_cfg_addr))
                    CFG_LOOKAHEAD:   r_look_cfg   <= i_cfg_wdata[0];
                    CFG_START_PRED:  r_start_pred <= i_cfg_wdata;
                    CFG_START_INDEX: r_start_idx  <= i_cfg_wdata[6:0];
                    default: ;
                endcase
            end
            if (commit) begin
                r_out_vld <= 1'b1;
            end else if (r_out_vld && m_axis_tready) begin
                r_out_vld <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (in_xfer) begin
                        r_cur      <= s_axis_tdata[15:0];
                        r_nxt      <= s_axis_tdata[31:16];
                        r_has_next <= s_axis_tuser[0];
                        r_look     <= r_look_cfg && s_axis_tuser[0];
                        if (s_axis_tuser[1]) begin
                            r_pred <= r_start_pred;
                            r_idx  <= (r_start_idx > IDX_MAX) ? IDX_MAX : r_start_idx;
                            r_odd  <= 1'b0;
                        end
                        r_k     <= '0;
                        r_best  <= '0;
                        r_have  <= 1'b0;
                        r_state <= S_OISSUE;
                    end
                end
                S_OISSUE: r_state <= S_OWAIT;
                S_OWAIT: begin
                    if (u_done) begin
                        r_d  <= {1'b0, u_sq};
                        r_tp <= u_tp;
                        r_ti <= u_ti;
                        if (r_look && (!r_have || {1'b0, u_sq} < r_best_d)) begin
                            r_iss   <= '0;
                            r_got   <= '0;
                            r_state <= S_INNER;
                        end else begin
                            r_state <= S_OCMP;
                        end
                    end
                end
                S_INNER: begin
                    if (!r_iss[4]) r_iss <= r_iss + 5'd1;
                    if (u_done) begin
                        r_min <= min_next;
                        r_got <= r_got + 4'd1;
                        if (r_got == 4'd15) begin
                            r_d     <= r_d + {1'b0, min_next};
                            r_state <= S_OCMP;
                        end
                    end
                end
                S_OCMP: begin
                    if (beats) begin
                        r_best_d <= r_d;
                        r_best   <= r_k;
                        r_have   <= 1'b1;
                    end
                    r_k     <= r_k + 4'd1;
                    r_state <= (r_k == 4'd15) ? S_FISSUE : S_OISSUE;
                end
                S_FISSUE: r_state <= S_FWAIT;
                S_FWAIT: begin
                    if (u_done || !u_go) begin
                        if (commit) begin
                            r_pred    <= u_tp;
                            r_idx     <= u_ti;
                            r_o_nib   <= r_best;
                            r_o_recon <= u_tp[15:8];
                            r_o_byte  <= r_odd ? {r_held, r_best} : {r_best, 4'd0};
                            r_o_ready <= r_odd || !r_has_next;
                            if (!r_odd) r_held <= r_best;
                            r_odd     <= !r_odd;
                            r_state   <= S_IDLE;
                        end else if (u_done) begin
                            r_tp    <= u_tp;
                            r_ti    <= u_ti;
                            r_state <= S_FISSUE;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {4'd0, r_o_byte, r_o_recon, r_o_nib};
    assign m_axis_tuser  = r_o_ready;

endmodule

`default_nettype wire

### design/adpcm_se_unit.sv
// shared trial unit: applies one nibble to a predictor and index, then squares
// the error against a target sample; three register stages; uses adpcm_se_pkg
`timescale 1ns / 1ps
`default_nettype none

module adpcm_se_unit
    import adpcm_se_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_go,
    input  wire logic signed [15:0] i_pred,
    input  wire logic        [6:0]  i_idx,
    input  wire logic        [3:0]  i_nib,
    input  wire logic signed [15:0] i_target,
    output logic                    o_done,
    output logic signed [15:0]      o_pred,
    output logic        [6:0]       o_idx,
    output logic        [31:0]      o_sq
);

    logic [2:0]         r_vld;
    logic signed [15:0] r_tp1, r_tp2, r_tp3;
    logic [6:0]         r_ti1, r_ti2, r_ti3;
    logic signed [15:0] r_tgt1;
    logic [15:0]        r_mag;
    logic [31:0]        r_sq;

    logic [14:0]        step;
    logic [15:0]        diff;
    logic signed [17:0] p_sum;
    logic signed [15:0] n_tp;
    logic signed [8:0]  ni_sum;
    logic [6:0]         n_ti;
    logic signed [16:0] err;
    logic [15:0]        n_mag;

    always_comb begin
        step = step_size(i_idx);
        diff = {4'd0, step[14:3]};
        if (i_nib[2]) diff = diff + {1'b0, step};
        if (i_nib[1]) diff = diff + {2'd0, step[14:1]};
        if (i_nib[0]) diff = diff + {3'd0, step[14:2]};
        if (i_nib[3]) p_sum = 18'(i_pred) - $signed({2'b00, diff});
        else          p_sum = 18'(i_pred) + $signed({2'b00, diff});
        if (p_sum > 18'sd32767)       n_tp = PRED_POS;
        else if (p_sum < -18'sd32768) n_tp = PRED_NEG;
        else                          n_tp = p_sum[15:0];
        ni_sum = $signed({2'b00, i_idx}) + 9'(idx_adjust(i_nib[2:0]));
        if (ni_sum < 9'sd0)                      n_ti = 7'd0;
        else if (ni_sum > $signed({2'b00, IDX_MAX})) n_ti = IDX_MAX;
        else                                     n_ti = ni_sum[6:0];
    end

    always_comb begin
        err   = 17'(r_tgt1) - 17'(r_tp1);
        n_mag = err[16] ? 16'(-err) : err[15:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[1:0], i_go};
        end
        r_tp1  <= n_tp;
        r_ti1  <= n_ti;
        r_tgt1 <= i_target;
        r_tp2  <= r_tp1;
        r_ti2  <= r_ti1;
        r_mag  <= n_mag;
        r_tp3  <= r_tp2;
        r_ti3  <= r_ti2;
        r_sq   <= r_mag * r_mag;
    end

    assign o_done = r_vld[2];
    assign o_pred = r_tp3;
    assign o_idx  = r_ti3;
    assign o_sq   = r_sq;

endmodule

`default_nettype wire
